>>> sv/vfge_pkg.sv
// Shared types, constants and font tables for the VFD glyph frame encoder.
// No dependencies; imported by every design module of the block.
`default_nettype none

package vfge_pkg;

  // Fixed field widths.
  localparam int unsigned POS_W   = 4;
  localparam int unsigned CODE_W  = 8;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned GLYPH_W = 16;
  localparam int unsigned CFG_IDX_W = 8;

  // Grid layout and font limits.
  localparam int unsigned FONT_SIZE = 61;
  localparam logic [POS_W-1:0] POS_GLYPH_PLAIN = 4'd0;
  localparam logic [POS_W-1:0] POS_NUM_HOUR    = 4'd1;
  localparam logic [POS_W-1:0] POS_GLYPH_ANN   = 4'd2;
  localparam logic [POS_W-1:0] POS_NUM_PLAIN   = 4'd3;
  localparam logic [POS_W-1:0] POS_FIRST_WIDE  = 4'd4;

  // Code remapping on the wide (14-segment) grids and number limits.
  localparam logic [CODE_W-1:0] WIDE_DIGIT_MAX  = 8'd9;
  localparam logic [CODE_W-1:0] WIDE_DIGIT_OFS  = 8'd18;
  localparam logic [CODE_W-1:0] WIDE_UPPER_MIN  = 8'd47;
  localparam logic [CODE_W-1:0] WIDE_UPPER_OFS  = 8'd30;
  localparam logic [CODE_W-1:0] NUM_LIMIT       = 8'd100;

  // Reciprocal for division by ten of values below one hundred: x*205 >> 11.
  localparam logic [CODE_W-1:0] DIV10_MUL   = 8'd205;
  localparam int unsigned       DIV10_SHIFT = 11;

  // Small work queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AM_FLAG     = 8'd0,
    REG_PM_FLAG     = 8'd1,
    REG_HOUR_FLAG   = 8'd2,
    REG_COLON_FLAG  = 8'd3,
    REG_TIMER_FLAG  = 8'd4,
    REG_CLEAN_FLAG  = 8'd5,
    REG_PROBE_FLAG  = 8'd6,
    REG_ADDRESS_CMD = 8'd7
  } reg_idx_t;

  localparam logic [BYTE_W-1:0] ADDRESS_CMD_RESET = 8'd192;

  // Configuration register file contents.
  typedef struct packed {
    logic              am;
    logic              pm;
    logic              hour;
    logic              colon;
    logic              timer;
    logic              clean;
    logic              probe;
    logic [BYTE_W-1:0] address_cmd;
  } cfg_t;

  // One encoded grid waiting to be sent.
  typedef struct packed {
    logic              has_cmd;
    logic [BYTE_W-1:0] b0;
    logic [BYTE_W-1:0] b1;
    logic [BYTE_W-1:0] b2;
  } work_t;

  // Font: 7-segment digits in the first ten entries, 14-segment glyphs after.
  localparam logic [GLYPH_W-1:0] FONT [FONT_SIZE] = '{
    16'h0077, 16'h0012, 16'h005D, 16'h005B, 16'h003A, 16'h006B, 16'h006F, 16'h0052,
    16'h007F, 16'h007B, 16'h21C0, 16'h00C0, 16'h2001, 16'h20C1, 16'h2B0F, 16'h2AC9,
    16'h14C8, 16'h2162, 16'h2727, 16'h0224, 16'h21C5, 16'h22C5, 16'h02C6, 16'h22C3,
    16'h23C3, 16'h0421, 16'h23C7, 16'h22C7, 16'h08C8, 16'h0808, 16'h1CF8, 16'h0420,
    16'h1632, 16'h0000, 16'h2000, 16'h06A4, 16'h2A8D, 16'h2103, 16'h2A0D, 16'h21C3,
    16'h01C3, 16'h3383, 16'h03C6, 16'h2809, 16'h1204, 16'h1162, 16'h2102, 16'h0336,
    16'h1316, 16'h2307, 16'h01C7, 16'h3307, 16'h11C7, 16'h2291, 16'h0809, 16'h2306,
    16'h0522, 16'h1706, 16'h1430, 16'h0830, 16'h2421
  };

  // Font lookup; an index past the table reads as a blank glyph.
  function automatic logic [GLYPH_W-1:0] glyph_at(input logic [CODE_W-1:0] idx);
    logic [GLYPH_W-1:0] g;
    g = '0;
    if (idx < CODE_W'(FONT_SIZE)) begin
      g = FONT[idx[5:0]];
    end
    return g;
  endfunction

endpackage : vfge_pkg

`default_nettype wire

>>> sv/vfge_front.sv
// Front end: configuration registers, input acceptance and per-grid encoding.
// Depends on vfge_pkg; pushes one work entry per valid position into vfge_queue.
`default_nettype none

module vfge_front
  import vfge_pkg::*;
#(
  parameter int unsigned NUM_POSITIONS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // Configuration writes
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [BYTE_W-1:0]    cfg_wdata,
  output      cfg_t                 cfg,
  // Input beat
  input  wire logic                 in_beat,
  input  wire logic [POS_W-1:0]     position,
  input  wire logic [CODE_W-1:0]    char_code,
  // Queue push side
  output      logic                 push,
  output      work_t                push_entry
);

  cfg_t cfg_r;

  // Register file; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.am          <= 1'b0;
      cfg_r.pm          <= 1'b0;
      cfg_r.hour        <= 1'b0;
      cfg_r.colon       <= 1'b0;
      cfg_r.timer       <= 1'b0;
      cfg_r.clean       <= 1'b0;
      cfg_r.probe       <= 1'b0;
      cfg_r.address_cmd <= ADDRESS_CMD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_AM_FLAG:     cfg_r.am          <= cfg_wdata[0];
        REG_PM_FLAG:     cfg_r.pm          <= cfg_wdata[0];
        REG_HOUR_FLAG:   cfg_r.hour        <= cfg_wdata[0];
        REG_COLON_FLAG:  cfg_r.colon       <= cfg_wdata[0];
        REG_TIMER_FLAG:  cfg_r.timer       <= cfg_wdata[0];
        REG_CLEAN_FLAG:  cfg_r.clean       <= cfg_wdata[0];
        REG_PROBE_FLAG:  cfg_r.probe       <= cfg_wdata[0];
        REG_ADDRESS_CMD: cfg_r.address_cmd <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

  // Split a number below one hundred into tens and ones digits.
  logic [2*CODE_W-1:0] div_prod;
  logic [3:0]          tens;
  logic [CODE_W-1:0]   ones_full;

  assign div_prod  = char_code * DIV10_MUL;
  assign tens      = div_prod[DIV10_SHIFT +: 4];
  assign ones_full = char_code - {1'b0, tens, 3'b000} - {3'b000, tens, 1'b0};

  // Remap codes on the wide grids.
  logic [CODE_W-1:0] wide_idx;

  always_comb begin
    priority if (char_code <= WIDE_DIGIT_MAX) begin
      wide_idx = char_code + WIDE_DIGIT_OFS;
    end else if (char_code > WIDE_UPPER_MIN) begin
      wide_idx = char_code - WIDE_UPPER_OFS;
    end else begin
      wide_idx = char_code;
    end
  end

  // Font reads for each grid kind.
  logic [GLYPH_W-1:0] wide_g;
  logic [GLYPH_W-1:0] ones_g;
  logic [GLYPH_W-1:0] tens_g;
  logic [GLYPH_W-1:0] single_g;

  assign wide_g   = glyph_at(wide_idx);
  assign ones_g   = glyph_at({4'b0000, ones_full[3:0]});
  assign tens_g   = glyph_at({4'b0000, tens});
  assign single_g = glyph_at(char_code);

  // Classify the grid and assemble its three bytes.
  logic               in_range;
  logic               is_wide;
  logic               is_num;
  logic [GLYPH_W-1:0] w1;
  logic [GLYPH_W-1:0] w2;

  assign in_range = {1'b0, position} < (POS_W + 1)'(NUM_POSITIONS);
  assign is_wide  = position >= POS_FIRST_WIDE;
  assign is_num   = (position == POS_NUM_HOUR) || (position == POS_NUM_PLAIN);

  always_comb begin
    w1 = '0;
    w2 = '0;
    push_entry         = '0;
    push_entry.has_cmd = (position == POS_GLYPH_PLAIN);
    priority if (is_wide) begin
      push_entry.b0 = wide_g[7:0];
      push_entry.b1 = wide_g[15:8];
      push_entry.b2 = '0;
    end else if (is_num) begin
      if (char_code < NUM_LIMIT) begin
        w1 = (ones_g >> 5) | (tens_g << 3) | {13'd0, cfg_r.colon, 2'b00};
        w2 = tens_g >> 5;
        push_entry.b0 = {ones_g[4:0],
                         cfg_r.hour & (position == POS_NUM_HOUR), 2'b00};
        push_entry.b1 = w1[7:0];
        push_entry.b2 = w2[7:0];
      end
    end else begin
      w1 = (single_g << 3) | {14'd0, cfg_r.am, cfg_r.pm};
      w2 = single_g >> 5;
      if (position == POS_GLYPH_ANN) begin
        push_entry.b0 = {4'b0000, cfg_r.probe, 1'b0, cfg_r.timer, cfg_r.clean};
      end
      push_entry.b1 = w1[7:0];
      push_entry.b2 = w2[7:0];
    end
  end

  // Positions past the display are accepted and dropped.
  assign push = in_beat && in_range;

endmodule : vfge_front

`default_nettype wire

>>> sv/vfge_queue.sv
// Short work queue that decouples the encoder front from the byte serializer.
// Depends on vfge_pkg for the entry type and depth.
`default_nettype none

module vfge_queue
  import vfge_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  work_t      push_entry,
  output      logic  full,
  input  wire logic  pop,
  output      logic  not_empty,
  output      work_t head
);

  work_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign full      = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule : vfge_queue

`default_nettype wire

>>> sv/vfge_back.sv
// Back end: serializes one queued grid into its command and data beats.
// Depends on vfge_pkg; drives the result channel from registers alone.
`default_nettype none

module vfge_back
  import vfge_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  cfg_t                   cfg,
  input  wire logic              q_not_empty,
  input  work_t                  q_head,
  output      logic              q_pop,
  output      logic              out_valid,
  input  wire logic              out_ready,
  output      logic [BYTE_W-1:0] data_byte,
  output      logic              is_command,
  output      logic              last
);

  typedef enum logic [1:0] {
    BEAT_CMD = 2'd0,
    BEAT_B0  = 2'd1,
    BEAT_B1  = 2'd2,
    BEAT_B2  = 2'd3
  } beat_t;

  work_t cur_r;
  beat_t beat_r;
  logic  valid_r;
  logic  done;

  // The current grid finishes when its last beat is taken.
  assign done  = valid_r && out_ready && (beat_r == BEAT_B2);
  assign q_pop = q_not_empty && (!valid_r || done);

  // Beat sequencer and current-entry register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      beat_r  <= BEAT_CMD;
    end else begin
      if (q_pop) begin
        valid_r <= 1'b1;
        beat_r  <= q_head.has_cmd ? BEAT_CMD : BEAT_B0;
      end else if (done) begin
        valid_r <= 1'b0;
      end else if (valid_r && out_ready) begin
        unique case (beat_r)
          BEAT_CMD: beat_r <= BEAT_B0;
          BEAT_B0:  beat_r <= BEAT_B1;
          BEAT_B1:  beat_r <= BEAT_B2;
          BEAT_B2:  beat_r <= BEAT_B2;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_head;
    end
  end

  // Select the byte for the beat on offer.
  always_comb begin
    unique case (beat_r)
      BEAT_CMD: data_byte = cfg.address_cmd;
      BEAT_B0:  data_byte = cur_r.b0;
      BEAT_B1:  data_byte = cur_r.b1;
      BEAT_B2:  data_byte = cur_r.b2;
    endcase
  end

  assign out_valid  = valid_r;
  assign is_command = (beat_r == BEAT_CMD);
  assign last       = (beat_r == BEAT_B2);

endmodule : vfge_back

`default_nettype wire

>>> sv/vfd_glyph_frame_encoder_unit.sv
// Top level of the VFD glyph frame encoder: front, work queue and serializer.
// Depends on vfge_pkg, vfge_front, vfge_queue and vfge_back.
//
// Usage:
//   Input channel: one beat per grid, tdata = {char_code, position}.
//   Result channel: display bytes, one per beat; tuser marks the address
//   command byte, tlast marks the third data byte of a grid.
//   Configuration channel: cfg_index/cfg_data write one register per beat;
//   cfg_ready is always high. Write only while the block is idle.
// Throughput: one result beat per cycle from the serializer while out_tready
//   is high; a grid gives three data bytes, and position 0 adds the command
//   byte first. Positions past NUM_POSITIONS are accepted and produce nothing.
// Path: an input beat is written into the work queue, then loaded into the
//   serializer register, from which the first byte of the grid is offered.
// Stalls: while out_tready is low the offered byte holds; the two-entry queue
//   keeps taking input until it fills, then in_tready drops.
// Reset: synchronous active-low rst_n empties the queue and the serializer and
//   loads the register defaults (all flags zero, address command 0xC0).
`default_nettype none

module vfd_glyph_frame_encoder_unit
  import vfge_pkg::*;
#(
  parameter int unsigned NUM_POSITIONS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // Input stream
  input  wire logic                 in_tvalid,
  output      logic                 in_tready,
  input  wire logic [15:0]          in_tdata,   // [3:0] position, [11:4] char_code
  // Result stream
  output      logic                 out_tvalid,
  input  wire logic                 out_tready,
  output      logic [7:0]           out_tdata,  // [7:0] data_byte
  output      logic                 out_tuser,  // [0] is_command
  output      logic                 out_tlast,
  // Configuration writes
  input  wire logic                 cfg_valid,
  output      logic                 cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [BYTE_W-1:0]    cfg_data
);

  cfg_t  cfg;
  logic  push;
  work_t push_entry;
  logic  q_full;
  logic  q_pop;
  logic  q_not_empty;
  work_t q_head;
  logic  in_beat;

  assign cfg_ready = 1'b1;
  assign in_tready = !q_full;
  assign in_beat   = in_tvalid && in_tready;

  // Classify and encode incoming grids.
  vfge_front #(
    .NUM_POSITIONS (NUM_POSITIONS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_idx    (cfg_index),
    .cfg_wdata  (cfg_data),
    .cfg        (cfg),
    .in_beat    (in_beat),
    .position   (in_tdata[3:0]),
    .char_code  (in_tdata[11:4]),
    .push       (push),
    .push_entry (push_entry)
  );

  // Decoupling queue.
  vfge_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  // Serialize grids into bytes.
  vfge_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .data_byte   (out_tdata),
    .is_command  (out_tuser),
    .last        (out_tlast)
  );

endmodule : vfd_glyph_frame_encoder_unit

`default_nettype wire

>>> sv/vfge_checker.sv
// Port-level checks for the VFD glyph frame encoder, bound to the top level.
// Depends only on the result-channel port names of vfd_glyph_frame_encoder_unit.
`default_nettype none

module vfge_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic       out_tuser,
  input wire logic       out_tlast
);

  // Reset leaves nothing on offer.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result offered right after reset");

  // A stalled byte holds its value and markers.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result beat changed");

  // The command byte is never the closing byte of a grid.
  a_cmd_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> !out_tlast)
    else $error("command beat marked last");

  // A command byte is always followed by data, never by another command.
  a_cmd_then_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tuser |=> !(out_tvalid && out_tuser))
    else $error("two command beats in a row");

endmodule : vfge_checker

bind vfd_glyph_frame_encoder_unit vfge_checker u_vfge_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire
